### rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define KRLS_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("krls: same-cycle check failed");

// next-cycle implication
`define KRLS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("krls: next-cycle check failed");

`endif

### rtl/core/krls_pkg.sv
`default_nettype none

package krls_pkg;

    localparam int KMER_LEN_DEF  = 32;
    localparam int MAX_FUNCS_DEF = 16;
    localparam int MAX_STEPS_DEF = 32;
    localparam int RESULT_LIMIT  = 16;
    localparam int FUNC_W        = 4;
    localparam int CFG_IDX_W     = 3;

    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_C = 8'h43;
    localparam logic [7:0] CHAR_G = 8'h47;
    localparam logic [7:0] CHAR_T = 8'h54;
    localparam logic [7:0] CHAR_N = 8'h4E;

    localparam logic [CFG_IDX_W-1:0] CFG_HASH_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIG_BASES   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAG_BITS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TAG_MASK    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_MASK    = 3'd4;

    localparam logic [4:0]  HASH_COUNT_RST = 5'd1;
    localparam logic [5:0]  SIG_BASES_RST  = 6'd14;
    localparam logic [5:0]  TAG_BITS_RST   = 6'd2;
    localparam logic [7:0]  TAG_MASK_RST   = 8'd3;
    localparam logic [63:0] ROW_MASK_RST   = 64'd67108863;

    typedef logic [2:0] upc_t;

    localparam upc_t UPC_IDLE  = 3'd0;
    localparam upc_t UPC_FINIT = 3'd1;
    localparam upc_t UPC_STEP  = 3'd2;
    localparam upc_t UPC_EMIT  = 3'd3;
    localparam upc_t UPC_NEXTF = 3'd4;
    localparam upc_t UPC_WRAP  = 3'd5;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_WORK,
        COND_STEP_MORE,
        COND_OUT_FULL,
        COND_FUNC_MORE
    } cond_t;

    typedef struct packed {
        logic  take_in;
        logic  init_func;
        logic  exec_step;
        logic  emit;
        logic  next_func;
        cond_t cond;
        upc_t  target;
    } uword_t;

    typedef struct packed {
        logic no_work;
        logic step_more;
        logic out_full;
        logic func_more;
    } seq_flags_t;

    typedef struct packed {
        logic step_more;
        logic out_full;
        logic func_more;
    } hash_flags_t;

    typedef struct packed {
        logic [5:0] shift;
        logic [5:0] grab;
        logic       stop;
    } prog_entry_t;

    function automatic uword_t ucode_rom(input upc_t a);
        uword_t w;
        w = '0;
        case (a)
            UPC_IDLE: begin
                w.take_in = 1'b1;
                w.cond    = COND_NO_WORK;
                w.target  = UPC_IDLE;
            end
            UPC_FINIT: begin
                w.init_func = 1'b1;
                w.cond      = COND_NEVER;
                w.target    = UPC_IDLE;
            end
            UPC_STEP: begin
                w.exec_step = 1'b1;
                w.cond      = COND_STEP_MORE;
                w.target    = UPC_STEP;
            end
            UPC_EMIT: begin
                w.emit   = 1'b1;
                w.cond   = COND_OUT_FULL;
                w.target = UPC_EMIT;
            end
            UPC_NEXTF: begin
                w.next_func = 1'b1;
                w.cond      = COND_FUNC_MORE;
                w.target    = UPC_FINIT;
            end
            UPC_WRAP: begin
                w.cond   = COND_ALWAYS;
                w.target = UPC_IDLE;
            end
            default: begin
                w.cond   = COND_ALWAYS;
                w.target = UPC_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### rtl/core/krls_kmer.sv
`default_nettype none

module krls_kmer #(
    parameter int KMER_LEN = krls_pkg::KMER_LEN_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        base_fire,
    input  logic [7:0]  base_char,
    input  logic        reverse_strand,
    input  logic        read_start,
    output logic [63:0] code_string,
    output logic [63:0] kmer_planes,
    output logic        full_next
);
    import krls_pkg::*;

    localparam int RUN_W = $clog2(KMER_LEN + 1);

    logic [KMER_LEN-1:0]   hi_reg, hi_next, lo_reg, lo_next, hi_base, lo_base;
    logic [2*KMER_LEN-1:0] code_reg, code_next, code_base;
    logic [RUN_W-1:0]      run_reg, run_next, run_base, run_inc;
    logic [1:0]            code;
    logic                  is_n;

    always_comb begin
        if (!reverse_strand) begin
            case (base_char)
                CHAR_T:  code = 2'd3;
                CHAR_G:  code = 2'd2;
                CHAR_C:  code = 2'd1;
                default: code = 2'd0;
            endcase
        end else begin
            case (base_char)
                CHAR_A:  code = 2'd3;
                CHAR_C:  code = 2'd2;
                CHAR_G:  code = 2'd1;
                default: code = 2'd0;
            endcase
        end
        is_n      = (base_char == CHAR_N);
        hi_base   = read_start ? '0 : hi_reg;
        lo_base   = read_start ? '0 : lo_reg;
        code_base = read_start ? '0 : code_reg;
        run_base  = read_start ? '0 : run_reg;
        run_inc   = (run_base < RUN_W'(KMER_LEN)) ? run_base + RUN_W'(1) : run_base;
        full_next = !is_n && (run_inc == RUN_W'(KMER_LEN));

        hi_next   = hi_reg;
        lo_next   = lo_reg;
        code_next = code_reg;
        run_next  = run_reg;
        if (base_fire) begin
            if (is_n) begin
                hi_next   = '0;
                lo_next   = '0;
                code_next = '0;
                run_next  = '0;
            end else begin
                hi_next   = {hi_base[KMER_LEN-2:0], code[1]};
                lo_next   = {lo_base[KMER_LEN-2:0], code[0]};
                code_next = {code_base[2*KMER_LEN-3:0], code};
                run_next  = run_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hi_reg   <= '0;
            lo_reg   <= '0;
            code_reg <= '0;
            run_reg  <= '0;
        end else begin
            hi_reg   <= hi_next;
            lo_reg   <= lo_next;
            code_reg <= code_next;
            run_reg  <= run_next;
        end
    end

    assign kmer_planes = {32'(hi_reg), 32'(lo_reg)};
    assign code_string = 64'(code_reg);

endmodule

`default_nettype wire

### rtl/core/krls_useq.sv
`default_nettype none
`include "assert_macros.svh"

module krls_useq (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  krls_pkg::seq_flags_t flags,
    output krls_pkg::uword_t     cw
);
    import krls_pkg::*;

    upc_t upc_reg, upc_next;
    logic jump;

    always_comb begin
        cw = ucode_rom(upc_reg);
        case (cw.cond)
            COND_NEVER:     jump = 1'b0;
            COND_ALWAYS:    jump = 1'b1;
            COND_NO_WORK:   jump = flags.no_work;
            COND_STEP_MORE: jump = flags.step_more;
            COND_OUT_FULL:  jump = flags.out_full;
            COND_FUNC_MORE: jump = flags.func_more;
            default:        jump = 1'b1;
        endcase
        upc_next = jump ? cw.target : upc_reg + upc_t'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= UPC_IDLE;
        end else begin
            upc_reg <= upc_next;
        end
    end

    `KRLS_ASSERT_SAME(a_upc_range, aclk, aresetn, 1'b1, upc_reg <= UPC_WRAP)
    `KRLS_ASSERT_NEXT(a_work_starts, aclk, aresetn, cw.take_in && !flags.no_work, upc_reg == UPC_FINIT)

endmodule

`default_nettype wire

### rtl/core/krls_hash.sv
`default_nettype none
`include "assert_macros.svh"

module krls_hash #(
    parameter int MAX_FUNCS = krls_pkg::MAX_FUNCS_DEF,
    parameter int MAX_STEPS = krls_pkg::MAX_STEPS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  krls_pkg::uword_t      cw,
    input  logic [4:0]            nf,
    input  logic [5:0]            signature_bases,
    input  logic [5:0]            tag_bits,
    input  logic [7:0]            tag_mask,
    input  logic [63:0]           row_mask,
    input  logic                  load_fire,
    input  logic [3:0]            func_slot,
    input  logic [4:0]            step_slot,
    input  logic [5:0]            step_shift,
    input  logic [5:0]            step_grab,
    input  logic                  step_end,
    input  logic [63:0]           code_string,
    input  logic [63:0]           kmer_planes,
    output krls_pkg::hash_flags_t flags,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [3:0]            m_func_index,
    output logic [63:0]           m_signature,
    output logic [7:0]            m_partition_tag,
    output logic [63:0]           m_row_hash,
    output logic [63:0]           m_kmer_planes,
    output logic                  m_last_of_run
);
    import krls_pkg::*;

    localparam int SW     = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int DEPTH  = MAX_FUNCS * MAX_STEPS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    prog_entry_t prog_mem [DEPTH];
    prog_entry_t rdata_reg, wr_entry;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic              wr_en;

    logic [63:0]       val_reg, val_next, res_reg, res_next, val_sh;
    logic [127:0]      funnel;
    logic [FUNC_W-1:0] f_reg, f_next;
    logic [SW-1:0]     s_reg, s_next, rd_idx;
    logic              s_last, func_last, out_full, emit_go;
    logic [6:0]        tag_pos;
    logic [7:0]        tag;

    logic        m_valid_reg, m_last_reg;
    logic [3:0]  m_func_reg;
    logic [63:0] m_sig_reg, m_row_reg, m_planes_reg;
    logic [7:0]  m_tag_reg;

    always_comb begin
        s_last    = (s_reg == SW'(MAX_STEPS - 1));
        func_last = (({1'b0, f_reg} + 5'd1) == nf);
        out_full  = m_valid_reg && !m_ready;
        emit_go   = cw.emit && !out_full;
        val_sh    = val_reg << rdata_reg.shift;
        funnel    = {res_reg, val_sh} << rdata_reg.grab;

        f_next   = f_reg;
        s_next   = s_reg;
        val_next = val_reg;
        res_next = res_reg;
        if (cw.take_in) begin
            f_next = '0;
        end
        if (cw.next_func) begin
            f_next = f_reg + FUNC_W'(1);
        end
        if (cw.init_func) begin
            val_next = code_string;
            res_next = '0;
            s_next   = '0;
        end
        if (cw.exec_step && !rdata_reg.stop) begin
            val_next = val_sh;
            res_next = funnel[127:64];
            if (!s_last) begin
                s_next = s_reg + SW'(1);
            end
        end

        rd_idx  = cw.init_func ? '0 : (s_last ? s_reg : s_reg + SW'(1));
        rd_addr = ADDR_W'(int'(f_reg) * MAX_STEPS) + ADDR_W'(rd_idx);

        wr_en    = load_fire && (int'(func_slot) < MAX_FUNCS) && (int'(step_slot) < MAX_STEPS);
        wr_addr  = ADDR_W'(int'(func_slot) * MAX_STEPS) + ADDR_W'(int'(step_slot));
        wr_entry = '{shift: step_shift, grab: step_grab, stop: step_end};

        tag_pos = {signature_bases, 1'b0} - {1'b0, tag_bits};
        tag     = 8'(res_reg >> tag_pos[5:0]) & tag_mask;

        flags.step_more = !rdata_reg.stop && !s_last;
        flags.out_full  = out_full;
        flags.func_more = !func_last;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            prog_mem[wr_addr] <= wr_entry;
        end
        rdata_reg <= prog_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_reg <= '0;
            s_reg <= '0;
        end else begin
            f_reg <= f_next;
            s_reg <= s_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
        res_reg <= res_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_go) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_go) begin
            m_func_reg   <= f_reg;
            m_sig_reg    <= res_reg;
            m_tag_reg    <= tag;
            m_row_reg    <= res_reg & row_mask;
            m_planes_reg <= kmer_planes;
            m_last_reg   <= func_last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_func_index    = m_func_reg;
    assign m_signature     = m_sig_reg;
    assign m_partition_tag = m_tag_reg;
    assign m_row_hash      = m_row_reg;
    assign m_kmer_planes   = m_planes_reg;
    assign m_last_of_run   = m_last_reg;

    `KRLS_ASSERT_NEXT(a_emit_loads, aclk, aresetn, emit_go, m_valid_reg && (m_func_reg == $past(f_reg)))
    `KRLS_ASSERT_NEXT(a_init_clears, aclk, aresetn, cw.init_func, (res_reg == 64'd0) && (s_reg == '0))

endmodule

`default_nettype wire

### rtl/core/kmer_rolling_lsh_signature_top.sv
// channel | direction | beat                                    | handshake
// s_      | in        | base byte or one program step load      | s_valid / s_ready
// m_      | out       | one signature per hash function in use  | m_valid / m_ready
// cfg_    | in        | register write, index and data          | cfg_valid / cfg_ready
// Loads, N bytes and bases before the run is full are taken in the idle step alone.
// A base with results runs, per function in use, an init step, program steps over the
// entries up to and including the terminator (at most MAX_STEPS), an emit step and a
// next-function step, then a wrap step; the program memory delivers one entry per cycle.
// A stalled m_ channel holds the sequencer in its emit step; s_ready drops until done.
// Reset is synchronous: run state clears, registers take their defaults, the program stays unknown.
`default_nettype none

module kmer_rolling_lsh_signature_top #(
    parameter int KMER_LEN  = krls_pkg::KMER_LEN_DEF,
    parameter int MAX_FUNCS = krls_pkg::MAX_FUNCS_DEF,
    parameter int MAX_STEPS = krls_pkg::MAX_STEPS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_action,
    input  logic [7:0]                     s_base_char,
    input  logic                           s_reverse_strand,
    input  logic                           s_read_start,
    input  logic [3:0]                     s_func_slot,
    input  logic [4:0]                     s_step_slot,
    input  logic [5:0]                     s_step_shift,
    input  logic [5:0]                     s_step_grab,
    input  logic                           s_step_end,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [3:0]                     m_func_index,
    output logic [63:0]                    m_signature,
    output logic [7:0]                     m_partition_tag,
    output logic [63:0]                    m_row_hash,
    output logic [63:0]                    m_kmer_planes,
    output logic                           m_last_of_run,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [krls_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                    cfg_data
);
    import krls_pkg::*;

    localparam int FUNC_CAP = (MAX_FUNCS < RESULT_LIMIT) ? MAX_FUNCS : RESULT_LIMIT;

    logic [4:0]  hash_count_reg;
    logic [5:0]  sig_bases_reg, tag_bits_reg;
    logic [7:0]  tag_mask_reg;
    logic [63:0] row_mask_reg;

    uword_t      cw;
    seq_flags_t  seq_flags;
    hash_flags_t hash_flags;
    logic        s_fire, base_fire, load_fire, full_next;
    logic [4:0]  nf;
    logic [63:0] code_string, kmer_planes;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_count_reg <= HASH_COUNT_RST;
            sig_bases_reg  <= SIG_BASES_RST;
            tag_bits_reg   <= TAG_BITS_RST;
            tag_mask_reg   <= TAG_MASK_RST;
            row_mask_reg   <= ROW_MASK_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_HASH_COUNT: hash_count_reg <= cfg_data[4:0];
                CFG_SIG_BASES:  sig_bases_reg  <= cfg_data[5:0];
                CFG_TAG_BITS:   tag_bits_reg   <= cfg_data[5:0];
                CFG_TAG_MASK:   tag_mask_reg   <= cfg_data[7:0];
                CFG_ROW_MASK:   row_mask_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg_ready = 1'b1;
        s_ready   = cw.take_in;
        s_fire    = s_valid && s_ready;
        base_fire = s_fire && !s_action;
        load_fire = s_fire && s_action;
        nf        = (hash_count_reg > 5'(FUNC_CAP)) ? 5'(FUNC_CAP) : hash_count_reg;

        seq_flags.no_work   = !(base_fire && full_next && (nf != 5'd0));
        seq_flags.step_more = hash_flags.step_more;
        seq_flags.out_full  = hash_flags.out_full;
        seq_flags.func_more = hash_flags.func_more;
    end

    krls_useq u_useq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (seq_flags),
        .cw      (cw)
    );

    krls_kmer #(
        .KMER_LEN (KMER_LEN)
    ) u_kmer (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .base_fire      (base_fire),
        .base_char      (s_base_char),
        .reverse_strand (s_reverse_strand),
        .read_start     (s_read_start),
        .code_string    (code_string),
        .kmer_planes    (kmer_planes),
        .full_next      (full_next)
    );

    krls_hash #(
        .MAX_FUNCS (MAX_FUNCS),
        .MAX_STEPS (MAX_STEPS)
    ) u_hash (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cw              (cw),
        .nf              (nf),
        .signature_bases (sig_bases_reg),
        .tag_bits        (tag_bits_reg),
        .tag_mask        (tag_mask_reg),
        .row_mask        (row_mask_reg),
        .load_fire       (load_fire),
        .func_slot       (s_func_slot),
        .step_slot       (s_step_slot),
        .step_shift      (s_step_shift),
        .step_grab       (s_step_grab),
        .step_end        (s_step_end),
        .code_string     (code_string),
        .kmer_planes     (kmer_planes),
        .flags           (hash_flags),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_func_index    (m_func_index),
        .m_signature     (m_signature),
        .m_partition_tag (m_partition_tag),
        .m_row_hash      (m_row_hash),
        .m_kmer_planes   (m_kmer_planes),
        .m_last_of_run   (m_last_of_run)
    );

endmodule

`default_nettype wire
